FILE: hdl/rtcf_pkg.sv
package rtcf_pkg;

    localparam int CHANNEL_BITS  = 8;
    localparam int FRACTION_BITS = 16;
    localparam int LENGTH_BITS   = 16;
    localparam int TIME_BITS     = 32;
    localparam int FRAC_W        = FRACTION_BITS + 1;
    localparam int ACC_BITS      = CHANNEL_BITS + FRACTION_BITS + 1;
    localparam int STEP_MAX      = (FRACTION_BITS > CHANNEL_BITS) ? FRACTION_BITS : CHANNEL_BITS;
    localparam int STEP_BITS     = $clog2(STEP_MAX);
    localparam int ADDR_BITS     = 5;
    localparam int DATA_BITS     = 32;

    localparam logic [2:0] REG_START_RED    = 3'd0;
    localparam logic [2:0] REG_START_GREEN  = 3'd1;
    localparam logic [2:0] REG_START_BLUE   = 3'd2;
    localparam logic [2:0] REG_TARGET_RED   = 3'd3;
    localparam logic [2:0] REG_TARGET_GREEN = 3'd4;
    localparam logic [2:0] REG_TARGET_BLUE  = 3'd5;
    localparam logic [2:0] REG_FADE_LENGTH  = 3'd6;
    localparam logic [2:0] REG_FADE_BEGIN   = 3'd7;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_MUL,
        ST_LOAD
    } rtcf_state_t;

    typedef struct packed {
        logic load;
        logic step;
    } rtcf_blend_ctrl_t;

endpackage

FILE: hdl/rtcf_blend.sv
module rtcf_blend (
    input  logic                                 clk,
    input  rtcf_pkg::rtcf_blend_ctrl_t           ctrl,
    input  logic [rtcf_pkg::CHANNEL_BITS-1:0]    from_val,
    input  logic [rtcf_pkg::CHANNEL_BITS-1:0]    to_val,
    input  logic [rtcf_pkg::FRAC_W-1:0]          frac,
    output logic [rtcf_pkg::CHANNEL_BITS-1:0]    result
);

    localparam int CB = rtcf_pkg::CHANNEL_BITS;
    localparam int FB = rtcf_pkg::FRACTION_BITS;
    localparam int AB = rtcf_pkg::ACC_BITS;

    logic [CB-1:0] from_reg, from_next;
    logic [CB-1:0] mag_reg, mag_next;
    logic          neg_reg, neg_next;
    logic [AB-1:0] acc_reg, acc_next;
    logic [AB-1:0] acc_round;
    logic [CB-1:0] step_val;

    // The magnitude is consumed most significant bit first, one bit per cycle.
    always_comb
    begin
        from_next = from_reg;
        mag_next  = mag_reg;
        neg_next  = neg_reg;
        acc_next  = acc_reg;
        if (ctrl.load)
        begin
            from_next = from_val;
            neg_next  = (to_val < from_val);
            mag_next  = (to_val < from_val) ? (from_val - to_val) : (to_val - from_val);
            acc_next  = '0;
        end
        else if (ctrl.step)
        begin
            acc_next = {acc_reg[AB-2:0], 1'b0}
                     + (mag_reg[CB-1] ? AB'(frac) : AB'(0));
            mag_next = {mag_reg[CB-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        from_reg <= from_next;
        mag_reg  <= mag_next;
        neg_reg  <= neg_next;
        acc_reg  <= acc_next;
    end

    // A falling channel rounds its step up so the result floors toward minus infinity.
    always_comb
    begin
        acc_round = neg_reg ? (acc_reg + AB'((1 << FB) - 1)) : acc_reg;
        step_val  = acc_round[FB+CB-1:FB];
        result    = neg_reg ? (from_reg - step_val) : (from_reg + step_val);
    end

endmodule

FILE: hdl/rgb_timed_color_fade.sv
// The result is registered in the load state. An item that finds the color at its target
// goes straight to the load state, one whose fade has run out passes through the bit-serial
// multipliers, one per channel, and one taken while a fade runs passes through the
// bit-serial divider and then the multipliers. No new item is taken until the result is
// registered; while an earlier result waits for out_ready, the load state holds off the next item.
// Reset: rst_n clears the color, the configuration registers and the handshake state at once.
module rgb_timed_color_fade (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [rtcf_pkg::ADDR_BITS-1:0]        paddr,
    input  logic [rtcf_pkg::DATA_BITS-1:0]        pwdata,
    output logic [rtcf_pkg::DATA_BITS-1:0]        prdata,
    output logic                                  pready,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [rtcf_pkg::TIME_BITS-1:0]        now_ms,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic [rtcf_pkg::CHANNEL_BITS-1:0]     red_out,
    output logic [rtcf_pkg::CHANNEL_BITS-1:0]     green_out,
    output logic [rtcf_pkg::CHANNEL_BITS-1:0]     blue_out,
    output logic                                  changing
);

    localparam int CB = rtcf_pkg::CHANNEL_BITS;
    localparam int FB = rtcf_pkg::FRACTION_BITS;
    localparam int LB = rtcf_pkg::LENGTH_BITS;
    localparam int TB = rtcf_pkg::TIME_BITS;
    localparam int FW = rtcf_pkg::FRAC_W;
    localparam int SB = rtcf_pkg::STEP_BITS;
    localparam int DB = rtcf_pkg::DATA_BITS;

    rtcf_pkg::rtcf_state_t state_reg, state_next;

    logic [CB-1:0] start_red_reg, start_green_reg, start_blue_reg;
    logic [CB-1:0] target_red_reg, target_green_reg, target_blue_reg;
    logic [LB-1:0] fade_length_reg;
    logic [TB-1:0] fade_begin_reg;

    logic [CB-1:0] cur_red_reg, cur_green_reg, cur_blue_reg;
    logic [CB-1:0] cur_red_next, cur_green_next, cur_blue_next;
    logic [CB-1:0] out_red_reg, out_green_reg, out_blue_reg;
    logic          out_changing_reg;
    logic          out_valid_reg, out_valid_next;
    logic          changing_reg, changing_next;
    logic [SB-1:0] cnt_reg, cnt_next;
    logic [LB-1:0] rem_reg, rem_next;
    logic [FW-1:0] frac_reg, frac_next;

    logic          accept;
    logic          cfg_write;
    logic [2:0]    cfg_index;
    logic          diff_now;
    logic [TB-1:0] elapsed;
    logic          elapsed_done;
    logic [LB:0]   rem_shift;
    logic          rem_ge;
    logic          div_last;
    logic          mul_last;
    logic          load_free;
    logic          div_run;
    logic          load_en;
    rtcf_pkg::rtcf_blend_ctrl_t blend_ctrl;

    logic [CB-1:0] red_blend, green_blend, blue_blend;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_index = paddr[4:2];

    always_comb
    begin
        case (cfg_index)
            rtcf_pkg::REG_START_RED:    prdata = DB'(start_red_reg);
            rtcf_pkg::REG_START_GREEN:  prdata = DB'(start_green_reg);
            rtcf_pkg::REG_START_BLUE:   prdata = DB'(start_blue_reg);
            rtcf_pkg::REG_TARGET_RED:   prdata = DB'(target_red_reg);
            rtcf_pkg::REG_TARGET_GREEN: prdata = DB'(target_green_reg);
            rtcf_pkg::REG_TARGET_BLUE:  prdata = DB'(target_blue_reg);
            rtcf_pkg::REG_FADE_LENGTH:  prdata = DB'(fade_length_reg);
            rtcf_pkg::REG_FADE_BEGIN:   prdata = DB'(fade_begin_reg);
            default:                    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_red_reg    <= '0;
            start_green_reg  <= '0;
            start_blue_reg   <= '0;
            target_red_reg   <= '0;
            target_green_reg <= '0;
            target_blue_reg  <= '0;
            fade_length_reg  <= '0;
            fade_begin_reg   <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rtcf_pkg::REG_START_RED:    start_red_reg    <= pwdata[CB-1:0];
                rtcf_pkg::REG_START_GREEN:  start_green_reg  <= pwdata[CB-1:0];
                rtcf_pkg::REG_START_BLUE:   start_blue_reg   <= pwdata[CB-1:0];
                rtcf_pkg::REG_TARGET_RED:   target_red_reg   <= pwdata[CB-1:0];
                rtcf_pkg::REG_TARGET_GREEN: target_green_reg <= pwdata[CB-1:0];
                rtcf_pkg::REG_TARGET_BLUE:  target_blue_reg  <= pwdata[CB-1:0];
                rtcf_pkg::REG_FADE_LENGTH:  fade_length_reg  <= pwdata[LB-1:0];
                rtcf_pkg::REG_FADE_BEGIN:   fade_begin_reg   <= pwdata[TB-1:0];
                default:                    fade_begin_reg   <= fade_begin_reg;
            endcase
        end
    end

    assign accept       = in_valid && in_ready;
    assign diff_now     = (cur_red_reg != target_red_reg) || (cur_green_reg != target_green_reg)
                       || (cur_blue_reg != target_blue_reg);
    assign elapsed      = now_ms - fade_begin_reg;
    assign elapsed_done = (elapsed >= TB'(fade_length_reg));
    assign rem_shift    = {rem_reg, 1'b0};
    assign rem_ge       = (rem_shift >= (LB+1)'(fade_length_reg));
    assign div_last     = (cnt_reg == SB'(FB - 1));
    assign mul_last     = (cnt_reg == SB'(CB - 1));
    assign load_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rtcf_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (!diff_now)
                        state_next = rtcf_pkg::ST_LOAD;
                    else if (elapsed_done)
                        state_next = rtcf_pkg::ST_MUL;
                    else
                        state_next = rtcf_pkg::ST_DIV;
                end
            end
            rtcf_pkg::ST_DIV:
            begin
                if (div_last)
                    state_next = rtcf_pkg::ST_MUL;
            end
            rtcf_pkg::ST_MUL:
            begin
                if (mul_last)
                    state_next = rtcf_pkg::ST_LOAD;
            end
            rtcf_pkg::ST_LOAD:
            begin
                if (load_free)
                    state_next = rtcf_pkg::ST_IDLE;
            end
            default:
                state_next = rtcf_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready        = 1'b0;
        div_run         = 1'b0;
        load_en         = 1'b0;
        blend_ctrl.load = 1'b0;
        blend_ctrl.step = 1'b0;
        case (state_reg)
            rtcf_pkg::ST_IDLE:
            begin
                in_ready        = 1'b1;
                blend_ctrl.load = 1'b1;
            end
            rtcf_pkg::ST_DIV:
                div_run = 1'b1;
            rtcf_pkg::ST_MUL:
                blend_ctrl.step = 1'b1;
            rtcf_pkg::ST_LOAD:
                load_en = load_free;
            default:
                in_ready = 1'b0;
        endcase
    end

    // Restoring division of the elapsed time by the fade length, one quotient bit per cycle.
    always_comb
    begin
        cnt_next       = cnt_reg;
        rem_next       = rem_reg;
        frac_next      = frac_reg;
        changing_next  = changing_reg;
        cur_red_next   = cur_red_reg;
        cur_green_next = cur_green_reg;
        cur_blue_next  = cur_blue_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (accept)
        begin
            changing_next = diff_now;
            cnt_next      = '0;
            rem_next      = elapsed[LB-1:0];
            frac_next     = elapsed_done ? FW'(1 << FB) : FW'(0);
        end
        else if (div_run)
        begin
            rem_next  = rem_ge ? LB'(rem_shift - (LB+1)'(fade_length_reg)) : rem_shift[LB-1:0];
            frac_next = {frac_reg[FW-2:0], rem_ge};
            cnt_next  = div_last ? SB'(0) : SB'(cnt_reg + 1'b1);
        end
        else if (blend_ctrl.step)
        begin
            cnt_next = SB'(cnt_reg + 1'b1);
        end
        if (load_en)
        begin
            out_valid_next = 1'b1;
            if (changing_reg)
            begin
                cur_red_next   = red_blend;
                cur_green_next = green_blend;
                cur_blue_next  = blue_blend;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= rtcf_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            cur_red_reg   <= '0;
            cur_green_reg <= '0;
            cur_blue_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
            cur_red_reg   <= cur_red_next;
            cur_green_reg <= cur_green_next;
            cur_blue_reg  <= cur_blue_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        frac_reg     <= frac_next;
        changing_reg <= changing_next;
        if (load_en)
        begin
            out_red_reg      <= cur_red_next;
            out_green_reg    <= cur_green_next;
            out_blue_reg     <= cur_blue_next;
            out_changing_reg <= changing_reg;
        end
    end

    rtcf_blend u_blend_red (
        .clk      (clk),
        .ctrl     (blend_ctrl),
        .from_val (start_red_reg),
        .to_val   (target_red_reg),
        .frac     (frac_reg),
        .result   (red_blend)
    );

    rtcf_blend u_blend_green (
        .clk      (clk),
        .ctrl     (blend_ctrl),
        .from_val (start_green_reg),
        .to_val   (target_green_reg),
        .frac     (frac_reg),
        .result   (green_blend)
    );

    rtcf_blend u_blend_blue (
        .clk      (clk),
        .ctrl     (blend_ctrl),
        .from_val (start_blue_reg),
        .to_val   (target_blue_reg),
        .frac     (frac_reg),
        .result   (blue_blend)
    );

    assign out_valid = out_valid_reg;
    assign red_out   = out_red_reg;
    assign green_out = out_green_reg;
    assign blue_out  = out_blue_reg;
    assign changing  = out_changing_reg;

`ifndef SYNTH
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rtcf_pkg::ST_DIV) |-> (fade_length_reg != '0))
        else $error("Division started with a zero fade length.");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rtcf_pkg::ST_DIV) |-> (rem_reg < fade_length_reg))
        else $error("Divider remainder is not below the fade length.");

    a_frac_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == rtcf_pkg::ST_MUL) |-> (frac_reg <= FW'(1 << FB)))
        else $error("Fade fraction exceeds one.");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> (out_valid_reg && $stable(out_red_reg)))
        else $error("A waiting result item was lost or changed.");
`endif

endmodule

FILE: dv/rgb_timed_color_fade_tb.sv
`timescale 1ns / 100ps

module rgb_timed_color_fade_tb;

    typedef struct packed {
        logic [rtcf_pkg::CHANNEL_BITS-1:0] red;
        logic [rtcf_pkg::CHANNEL_BITS-1:0] green;
        logic [rtcf_pkg::CHANNEL_BITS-1:0] blue;
        logic                              changing;
    } color_report_t;

    logic                              clk;
    logic                              rst_n;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [rtcf_pkg::ADDR_BITS-1:0]    paddr;
    logic [rtcf_pkg::DATA_BITS-1:0]    pwdata;
    logic [rtcf_pkg::DATA_BITS-1:0]    prdata;
    logic                              pready;
    logic                              in_valid;
    logic                              in_ready;
    logic [rtcf_pkg::TIME_BITS-1:0]    now_ms;
    logic                              out_valid;
    logic                              out_ready;
    logic [rtcf_pkg::CHANNEL_BITS-1:0] red_out;
    logic [rtcf_pkg::CHANNEL_BITS-1:0] green_out;
    logic [rtcf_pkg::CHANNEL_BITS-1:0] blue_out;
    logic                              changing;

    logic [rtcf_pkg::CHANNEL_BITS-1:0] start_red_q, start_green_q, start_blue_q;
    logic [rtcf_pkg::CHANNEL_BITS-1:0] target_red_q, target_green_q, target_blue_q;
    logic [rtcf_pkg::LENGTH_BITS-1:0]  fade_length_q;
    logic [rtcf_pkg::TIME_BITS-1:0]    fade_begin_q;
    logic [rtcf_pkg::CHANNEL_BITS-1:0] held_red, held_green, held_blue;

    color_report_t pending_reports[$];
    int unsigned   error_count;
    int unsigned   ticks_sent;
    bit            calm;

    rgb_timed_color_fade u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .now_ms    (now_ms),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .red_out   (red_out),
        .green_out (green_out),
        .blue_out  (blue_out),
        .changing  (changing)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [rtcf_pkg::CHANNEL_BITS-1:0] blend_channel(
        input logic [rtcf_pkg::CHANNEL_BITS-1:0] from,
        input logic [rtcf_pkg::CHANNEL_BITS-1:0] to,
        input longint                            frac
    );
        longint a;
        longint b;
        longint diff;
        longint step;
        a = longint'(from);
        b = longint'(to);
        diff = b - a;
        if (diff >= 0)
        begin
            step = (diff * frac) >>> rtcf_pkg::FRACTION_BITS;
        end
        else
        begin
            step = -(((-diff) * frac + (longint'(1) << rtcf_pkg::FRACTION_BITS) - 1)
                     >>> rtcf_pkg::FRACTION_BITS);
        end
        return rtcf_pkg::CHANNEL_BITS'(a + step);
    endfunction

    function automatic color_report_t predict_tick(input logic [rtcf_pkg::TIME_BITS-1:0] t);
        color_report_t rep;
        logic [rtcf_pkg::TIME_BITS-1:0] elapsed;
        longint e;
        longint len;
        longint frac;
        rep.changing = (held_red != target_red_q) || (held_green != target_green_q) ||
                       (held_blue != target_blue_q);
        if (rep.changing)
        begin
            elapsed = t - fade_begin_q;
            e = longint'(elapsed);
            len = longint'(fade_length_q);
            if (e >= len)
            begin
                frac = longint'(1) << rtcf_pkg::FRACTION_BITS;
            end
            else
            begin
                frac = (e << rtcf_pkg::FRACTION_BITS) / len;
            end
            held_red   = blend_channel(start_red_q, target_red_q, frac);
            held_green = blend_channel(start_green_q, target_green_q, frac);
            held_blue  = blend_channel(start_blue_q, target_blue_q, frac);
        end
        rep.red   = held_red;
        rep.green = held_green;
        rep.blue  = held_blue;
        return rep;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        color_report_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result with no item waiting: red %0d green %0d blue %0d changing %0d",
                       red_out, green_out, blue_out, changing);
                error_count++;
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("red_out", 32'(want.red), 32'(red_out));
                check_field("green_out", 32'(want.green), 32'(green_out));
                check_field("blue_out", 32'(want.blue), 32'(blue_out));
                check_field("changing", 32'(want.changing), 32'(changing));
            end
        end
        out_ready <= calm || ($urandom_range(0, 99) >= 19);
    end

    task automatic send_tick(input logic [rtcf_pkg::TIME_BITS-1:0] t);
        while (!calm && $urandom_range(0, 99) < 19)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        now_ms   <= t;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        pending_reports.push_back(predict_tick(t));
        ticks_sent++;
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_reg(input logic [2:0] idx,
                             input logic [rtcf_pkg::DATA_BITS-1:0] value);
        logic [rtcf_pkg::DATA_BITS-1:0] word;
        word = $urandom();
        case (idx)
            rtcf_pkg::REG_FADE_LENGTH:
                word[rtcf_pkg::LENGTH_BITS-1:0] = value[rtcf_pkg::LENGTH_BITS-1:0];
            rtcf_pkg::REG_FADE_BEGIN:
                word = value;
            default:
                word[rtcf_pkg::CHANNEL_BITS-1:0] = value[rtcf_pkg::CHANNEL_BITS-1:0];
        endcase
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= rtcf_pkg::ADDR_BITS'({idx, 2'b00});
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
        begin
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            rtcf_pkg::REG_START_RED:    start_red_q    = word[rtcf_pkg::CHANNEL_BITS-1:0];
            rtcf_pkg::REG_START_GREEN:  start_green_q  = word[rtcf_pkg::CHANNEL_BITS-1:0];
            rtcf_pkg::REG_START_BLUE:   start_blue_q   = word[rtcf_pkg::CHANNEL_BITS-1:0];
            rtcf_pkg::REG_TARGET_RED:   target_red_q   = word[rtcf_pkg::CHANNEL_BITS-1:0];
            rtcf_pkg::REG_TARGET_GREEN: target_green_q = word[rtcf_pkg::CHANNEL_BITS-1:0];
            rtcf_pkg::REG_TARGET_BLUE:  target_blue_q  = word[rtcf_pkg::CHANNEL_BITS-1:0];
            rtcf_pkg::REG_FADE_LENGTH:  fade_length_q  = word[rtcf_pkg::LENGTH_BITS-1:0];
            rtcf_pkg::REG_FADE_BEGIN:   fade_begin_q   = word;
            default:                    ;
        endcase
        @(posedge clk);
    endtask

    task automatic set_fade(input logic [rtcf_pkg::CHANNEL_BITS-1:0] sr, sg, sb, tr, tg, tb,
                            input logic [rtcf_pkg::LENGTH_BITS-1:0] len,
                            input logic [rtcf_pkg::TIME_BITS-1:0] at);
        drain_results();
        write_reg(rtcf_pkg::REG_START_RED, rtcf_pkg::DATA_BITS'(sr));
        write_reg(rtcf_pkg::REG_START_GREEN, rtcf_pkg::DATA_BITS'(sg));
        write_reg(rtcf_pkg::REG_START_BLUE, rtcf_pkg::DATA_BITS'(sb));
        write_reg(rtcf_pkg::REG_TARGET_RED, rtcf_pkg::DATA_BITS'(tr));
        write_reg(rtcf_pkg::REG_TARGET_GREEN, rtcf_pkg::DATA_BITS'(tg));
        write_reg(rtcf_pkg::REG_TARGET_BLUE, rtcf_pkg::DATA_BITS'(tb));
        write_reg(rtcf_pkg::REG_FADE_LENGTH, rtcf_pkg::DATA_BITS'(len));
        write_reg(rtcf_pkg::REG_FADE_BEGIN, rtcf_pkg::DATA_BITS'(at));
    endtask

    function automatic logic [rtcf_pkg::CHANNEL_BITS-1:0] pick_channel();
        int unsigned r;
        r = $urandom_range(0, 5);
        if (r == 0)
        begin
            return '0;
        end
        if (r == 1)
        begin
            return '1;
        end
        return rtcf_pkg::CHANNEL_BITS'($urandom());
    endfunction

    task automatic test_reset_color();
        send_tick(32'h0000_0000);
        send_tick(32'hFFFF_FFFF);
        send_tick($urandom());
    endtask

    task automatic test_zero_length();
        set_fade(8'd12, 8'd200, 8'd255, 8'd255, 8'd0, 8'd0, 16'd0, $urandom());
        send_tick($urandom());
        send_tick($urandom());
        send_tick(32'h0000_0000);
    endtask

    task automatic test_full_span();
        logic [rtcf_pkg::TIME_BITS-1:0] at;
        at = 32'hFFFF_FF00;
        set_fade(8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd128, 16'hFFFF, at);
        send_tick(at);
        send_tick(at + 1);
        send_tick(at + 256);
        send_tick(at + 32768);
        send_tick(at + 65534);
        send_tick(at + 65535);
        send_tick(at + 65536);
    endtask

    task automatic test_before_begin();
        set_fade(8'd255, 8'd255, 8'd255, 8'd0, 8'd0, 8'd0, 16'd1000, 32'd5000);
        send_tick(32'd4999);
        send_tick(32'd0);
        send_tick(32'd6000);
    endtask

    task automatic test_set_color();
        logic [rtcf_pkg::TIME_BITS-1:0] at;
        at = $urandom();
        set_fade(8'd77, 8'd88, 8'd99, 8'd77, 8'd88, 8'd99, 16'd500, at);
        send_tick(at);
        send_tick(at + 1);
    endtask

    task automatic test_short_fades();
        set_fade(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 16'd1, 32'd100);
        send_tick(32'd100);
        send_tick(32'd101);
        set_fade(8'd255, 8'd255, 8'd255, 8'd0, 8'd128, 8'd254, 16'd2, 32'hFFFF_FFFF);
        send_tick(32'hFFFF_FFFF);
        send_tick(32'h0000_0000);
        send_tick(32'h0000_0001);
    endtask

    task automatic test_random_fades();
        int unsigned                      fade_no;
        int unsigned                      r;
        int unsigned                      count;
        logic [rtcf_pkg::LENGTH_BITS-1:0] len;
        logic [rtcf_pkg::TIME_BITS-1:0]   at;
        logic [rtcf_pkg::TIME_BITS-1:0]   elapsed;
        fade_no = 0;
        while (ticks_sent < 1850)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                len = '0;
            end
            else if (r < 75)
            begin
                len = rtcf_pkg::LENGTH_BITS'($urandom_range(1, 300));
            end
            else if (r < 92)
            begin
                len = rtcf_pkg::LENGTH_BITS'($urandom_range(301, 65534));
            end
            else
            begin
                len = 16'hFFFF;
            end
            at = $urandom();
            drain_results();
            calm = (fade_no >= 40) && (fade_no < 60);
            set_fade(pick_channel(), pick_channel(), pick_channel(),
                     pick_channel(), pick_channel(), pick_channel(), len, at);
            count = $urandom_range(4, 24);
            elapsed = '0;
            repeat (count)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    send_tick($urandom());
                end
                else
                begin
                    send_tick(at + elapsed);
                end
                elapsed = elapsed + $urandom_range(0, len / 6 + 1);
            end
            fade_no++;
        end
        drain_results();
        calm = 1'b0;
    endtask

    initial
    begin
        rst_n     = 1'b0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;
        in_valid  = 1'b0;
        now_ms    = '0;
        out_ready = 1'b0;
        calm      = 1'b0;
        error_count = 0;
        ticks_sent  = 0;
        start_red_q = '0;
        start_green_q = '0;
        start_blue_q = '0;
        target_red_q = '0;
        target_green_q = '0;
        target_blue_q = '0;
        fade_length_q = '0;
        fade_begin_q = '0;
        held_red = '0;
        held_green = '0;
        held_blue = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_color();
        test_zero_length();
        test_full_span();
        test_before_begin();
        test_set_color();
        test_short_fades();
        test_random_fades();

        drain_results();
        repeat (40) @(posedge clk);
        if (pending_reports.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_reports.size());
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("PASS rgb_timed_color_fade");
        end
        else
        begin
            $display("FAIL rgb_timed_color_fade");
        end
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("FAIL rgb_timed_color_fade");
        $finish;
    end

endmodule

FILE: rgb_timed_color_fade.f
hdl/rtcf_pkg.sv
hdl/rtcf_blend.sv
hdl/rgb_timed_color_fade.sv
dv/rgb_timed_color_fade_tb.sv
